/* design/grouped_int_aggregate_defines.svh */
// Assertion macros shared by the grouped aggregation RTL.
`ifndef GROUPED_INT_AGGREGATE_DEFINES_SVH
`define GROUPED_INT_AGGREGATE_DEFINES_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define GIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gia assertion failed");
// Condition in one cycle that implies a condition in the next cycle.
`define GIA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("gia assertion failed");
`else
`define GIA_ASSERT(lbl, prop)
`define GIA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* design/gia_pkg.sv */
// Types, codes and helper functions of the grouped aggregation block.
package gia_pkg;

  localparam int GID_W      = 8;
  localparam int GID_SPAN   = 2 ** GID_W;
  localparam int VAL_W      = 64;
  localparam int ROW_W      = 32;
  localparam int OUT_SLOTS  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int GC_W       = 9;
  localparam int AC_W       = 3;
  localparam int FN_W       = 3;

  localparam logic [VAL_W-1:0] I64_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] I64_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGG_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT0_FN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT1_FN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT2_FN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT3_FN    = 3'd5;

  // Slot function codes
  localparam logic [FN_W-1:0] FN_SUM   = 3'd0;
  localparam logic [FN_W-1:0] FN_COUNT = 3'd1;
  localparam logic [FN_W-1:0] FN_MIN   = 3'd2;
  localparam logic [FN_W-1:0] FN_MAX   = 3'd3;
  localparam logic [FN_W-1:0] FN_ANY   = 3'd4;

  // Item operation codes
  localparam logic OP_ROW  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } gia_state_e;

  typedef struct packed {
    logic in_stall;
    logic exec_go;
  } gia_ctl_t;

  // Accumulator value of a slot that holds no data yet.
  function automatic logic [VAL_W-1:0] empty_value(input logic [FN_W-1:0] fn);
    logic [VAL_W-1:0] r;
    r = '0;
    if (fn == FN_MIN) r = I64_MAX;
    if (fn == FN_MAX) r = I64_MIN;
    return r;
  endfunction

endpackage

/* design/gia_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/gia_slot.sv */
// One aggregate slot lane: update of the stored accumulator and read result.
module gia_slot (
  input  logic [gia_pkg::FN_W-1:0]  fn_i,
  input  logic                      active_i,
  input  logic                      seen_i,
  input  logic [gia_pkg::VAL_W-1:0] acc_i,
  input  logic [gia_pkg::VAL_W-1:0] value_i,
  output logic                      upd_en_o,
  output logic [gia_pkg::VAL_W-1:0] upd_o,
  output logic [gia_pkg::VAL_W-1:0] result_o
);
  import gia_pkg::*;

  logic [VAL_W-1:0] acc;
  logic [VAL_W-1:0] upd;
  logic             fn_ok;

  // An unseen slot starts from the empty value of the current function.
  assign acc = seen_i ? acc_i : empty_value(fn_i);

  always_comb begin
    fn_ok = 1'b1;
    upd   = acc_i;
    case (fn_i)
      FN_SUM:   upd = acc + value_i;
      FN_COUNT: upd = (acc < I64_MAX) ? acc + VAL_W'(1) : acc;
      FN_MIN:   upd = ($signed(value_i) < $signed(acc)) ? value_i : acc;
      FN_MAX:   upd = ($signed(acc) < $signed(value_i)) ? value_i : acc;
      FN_ANY:   upd = seen_i ? acc : value_i;
      default:  fn_ok = 1'b0;
    endcase
  end

  assign upd_en_o = active_i && fn_ok;
  assign upd_o    = upd_en_o ? upd : acc_i;
  assign result_o = upd_en_o ? acc : '0;

endmodule

/* design/gia_ctrl.sv */
// Item sequencer: accept, memory read, then execute (write-back for a row, output for a read).
module gia_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_hit_i,
  input  logic              op_read_i,
  input  logic              out_free_i,
  output gia_pkg::gia_ctl_t ctl_o
);
  import gia_pkg::*;

  gia_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_hit_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        // hold a read until the output register can take its result
        if (!op_read_i || out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    unique case (state_q)
      ST_IDLE: ctl_o.in_stall = 1'b0;
      ST_EXEC: begin
        ctl_o.in_stall = 1'b1;
        ctl_o.exec_go  = !op_read_i || out_free_i;
      end
      default: ctl_o.in_stall = 1'b1;
    endcase
  end

endmodule

/* design/grouped_int_aggregate.sv */
// Per-group aggregation: an in-range item goes on to execute; a dropped item does not.
// The group row is read in the accept cycle; a row item writes it back in the next cycle.
// A read result is registered as execute completes and held while out_stall_i is high.
// The input stalls while an in-range item executes, so the next item waits for it.
// Reset: control and row-valid flops clear at once; seen bits ride with the row count.
// Registers reset to group_count 256, aggregate_count 0, all slot functions sum.
`include "grouped_int_aggregate_defines.svh"
module grouped_int_aggregate #(
  parameter int MAX_GROUPS = 256,
  parameter int MAX_SLOTS  = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gia_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gia_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             in_func_i,
  input  logic [gia_pkg::GID_W-1:0]        in_group_id_i,
  input  logic signed [gia_pkg::VAL_W-1:0] in_value_0_i,
  input  logic signed [gia_pkg::VAL_W-1:0] in_value_1_i,
  input  logic signed [gia_pkg::VAL_W-1:0] in_value_2_i,
  input  logic signed [gia_pkg::VAL_W-1:0] in_value_3_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gia_pkg::GID_W-1:0]        out_group_index_o,
  output logic [gia_pkg::ROW_W-1:0]        out_row_count_o,
  output logic signed [gia_pkg::VAL_W-1:0] out_result_0_o,
  output logic signed [gia_pkg::VAL_W-1:0] out_result_1_o,
  output logic signed [gia_pkg::VAL_W-1:0] out_result_2_o,
  output logic signed [gia_pkg::VAL_W-1:0] out_result_3_o
);
  import gia_pkg::*;

  localparam int GROUPS = (MAX_GROUPS < GID_SPAN) ? MAX_GROUPS : GID_SPAN;
  localparam int SLOTS  = (MAX_SLOTS < OUT_SLOTS) ? MAX_SLOTS : OUT_SLOTS;
  localparam int AW     = $clog2(GROUPS);
  localparam logic [GC_W-1:0] GROUPS_L = GC_W'(GROUPS);

  // configuration registers
  logic [GC_W-1:0]                group_count_q;
  logic [AC_W-1:0]                agg_count_q;
  logic [OUT_SLOTS-1:0][FN_W-1:0] slot_fn_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q <= GC_W'(GID_SPAN);
      agg_count_q   <= '0;
      slot_fn_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GROUP_COUNT: group_count_q <= cfg_data_i[GC_W-1:0];
        CFG_AGG_COUNT:   agg_count_q   <= cfg_data_i[AC_W-1:0];
        CFG_SLOT0_FN:    slot_fn_q[0]  <= cfg_data_i[FN_W-1:0];
        CFG_SLOT1_FN:    slot_fn_q[1]  <= cfg_data_i[FN_W-1:0];
        CFG_SLOT2_FN:    slot_fn_q[2]  <= cfg_data_i[FN_W-1:0];
        CFG_SLOT3_FN:    slot_fn_q[3]  <= cfg_data_i[FN_W-1:0];
        default: ;
      endcase
    end
  end

  // input acceptance and range check
  logic [GC_W-1:0] limit;
  logic            in_hit;
  logic            in_accept;
  gia_ctl_t        ctl;
  logic            out_valid_q;
  logic            out_free;

  assign limit     = (group_count_q < GROUPS_L) ? group_count_q : GROUPS_L;
  assign in_hit    = GC_W'(in_group_id_i) < limit;
  assign in_accept = in_valid_i && !ctl.in_stall;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = ctl.in_stall;

  // latched item
  logic                          op_q;
  logic [GID_W-1:0]              gid_q;
  logic [OUT_SLOTS-1:0][VAL_W-1:0] val_q;
  logic [AW-1:0]                 row_idx;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= in_func_i;
      gid_q    <= in_group_id_i;
      val_q[0] <= in_value_0_i;
      val_q[1] <= in_value_1_i;
      val_q[2] <= in_value_2_i;
      val_q[3] <= in_value_3_i;
    end
  end

  assign row_idx = gid_q[AW-1:0];

  gia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_hit_i   (in_hit),
    .op_read_i  (op_q == OP_READ),
    .out_free_i (out_free),
    .ctl_o      (ctl)
  );

  // group state memories and their row-valid flops
  logic                        row_wr;
  logic                        rd_en;
  logic [ROW_W+SLOTS-1:0]      grp_rdata;
  logic [ROW_W+SLOTS-1:0]      grp_wdata;
  logic [ROW_W-1:0]            cnt;
  logic [ROW_W-1:0]            cnt_next;
  logic [SLOTS-1:0]            seen;
  logic [SLOTS*VAL_W-1:0]      acc_rdata;
  logic [SLOTS*VAL_W-1:0]      acc_wdata;
  logic [GROUPS-1:0]           rvld_q;
  logic [SLOTS-1:0]            upd_en;

  assign row_wr = ctl.exec_go && (op_q == OP_ROW);
  assign rd_en  = in_accept && in_hit;

  gia_ram #(.WIDTH(ROW_W+SLOTS), .DEPTH(GROUPS)) u_cnt_ram (
    .clk_i     (clk_i),
    .wr_en_i   (row_wr),
    .wr_addr_i (row_idx),
    .wr_data_i (grp_wdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (in_group_id_i[AW-1:0]),
    .rd_data_o (grp_rdata)
  );

  gia_ram #(.WIDTH(SLOTS*VAL_W), .DEPTH(GROUPS)) u_acc_ram (
    .clk_i     (clk_i),
    .wr_en_i   (row_wr),
    .wr_addr_i (row_idx),
    .wr_data_i (acc_wdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (in_group_id_i[AW-1:0]),
    .rd_data_o (acc_rdata)
  );

  // a group without its row-valid bit reads as never seen
  assign cnt       = rvld_q[row_idx] ? grp_rdata[ROW_W-1:0] : '0;
  assign seen      = rvld_q[row_idx] ? grp_rdata[ROW_W +: SLOTS] : '0;
  assign cnt_next  = (cnt != '1) ? cnt + ROW_W'(1) : cnt;
  assign grp_wdata = {seen | upd_en, cnt_next};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= '0;
    end else if (ctl.exec_go) begin
      // a read drops the group back to never seen
      rvld_q[row_idx] <= (op_q == OP_ROW);
    end
  end

  // slot lanes
  logic [OUT_SLOTS-1:0][VAL_W-1:0] result;

  for (genvar s = 0; s < OUT_SLOTS; s++) begin : g_slot
    if (s < SLOTS) begin : g_lane
      logic [VAL_W-1:0] upd;
      gia_slot u_slot (
        .fn_i     (slot_fn_q[s]),
        .active_i (agg_count_q > AC_W'(s)),
        .seen_i   (seen[s]),
        .acc_i    (acc_rdata[s*VAL_W +: VAL_W]),
        .value_i  (val_q[s]),
        .upd_en_o (upd_en[s]),
        .upd_o    (upd),
        .result_o (result[s])
      );
      assign acc_wdata[s*VAL_W +: VAL_W] = upd;
    end else begin : g_none
      assign result[s] = '0;
    end
  end

  // output register
  logic [GID_W-1:0]                out_gid_q;
  logic [ROW_W-1:0]                out_cnt_q;
  logic [OUT_SLOTS-1:0][VAL_W-1:0] out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.exec_go && (op_q == OP_READ)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.exec_go && (op_q == OP_READ)) begin
      out_gid_q <= gid_q;
      out_cnt_q <= cnt;
      out_res_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_group_index_o = out_gid_q;
  assign out_row_count_o   = out_cnt_q;
  assign out_result_0_o    = out_res_q[0];
  assign out_result_1_o    = out_res_q[1];
  assign out_result_2_o    = out_res_q[2];
  assign out_result_3_o    = out_res_q[3];

  // an in-range item always occupies the execute cycle next
  `GIA_ASSERT_NEXT(a_hit_exec, in_accept && in_hit, ctl.in_stall)
  // a dropped item never produces a result
  `GIA_ASSERT_NEXT(a_drop_silent, in_accept && !in_hit && !out_valid_q, !out_valid_q)
  // a completed read presents its result and leaves its group cleared
  `GIA_ASSERT_NEXT(a_read_out, ctl.exec_go && (op_q == OP_READ),
                   out_valid_q && !rvld_q[$past(row_idx)])

endmodule
